// ----- hdl/drst_pkg.sv -----
// Shared types and command codes of the dirty row span tracker.
package drst_pkg;

	localparam int TEXT_ROWS    = 24;
	localparam int TEXT_COLS    = 80;
	localparam int VISIBLE_COLS = 64;

	localparam int COL_W  = 7;   // stored column values, including the clean marker
	localparam int WIDE_W = 8;   // column sums of origin and window width

	localparam logic [2:0] FUNC_MARK    = 3'd0;
	localparam logic [2:0] FUNC_ALL     = 3'd1;
	localparam logic [2:0] FUNC_PAN     = 3'd2;
	localparam logic [2:0] FUNC_CLEAR   = 3'd3;
	localparam logic [2:0] FUNC_REFRESH = 3'd4;

	typedef struct packed {
		logic mark;
		logic mark_all;
		logic pan;
		logic clear;
		logic walk;
		logic sum;
	} drst_cmd_t;

	typedef struct packed {
		logic walk_last;
	} drst_status_t;

endpackage

// ----- hdl/dirty_row_span_tracker.sv -----
// Top level of the dirty row span tracker: controller and datapath.
//
// A request is taken at a rising edge with start high and busy low. Fields
// row, from_col, to_col and view_col are read only by the requests that use
// them. Span marks, mark-all, pan and clear-view requests complete in the
// accepting cycle, so busy stays low and a new request may follow in the
// next cycle.
// A refresh raises busy while it walks the rows, reading and cleaning one row of
// the span registers each cycle, and while it then forms the summary. Span
// results appear with strobe high in the cycle after their row is visited; the
// summary (kind and last high) follows in the first cycle after busy falls.
// Each result is shown for exactly one cycle; the receiver cannot stall.
// Reset clears every row, drops the viewport and zeroes the refresh count.
module dirty_row_span_tracker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] func,
	input  logic [4:0] row,
	input  logic [6:0] from_col,
	input  logic [6:0] to_col,
	input  logic [6:0] view_col,
	output logic       strobe,
	output logic       kind,
	output logic [4:0] span_row,
	output logic [6:0] row_origin,
	output logic [5:0] head_cell,
	output logic [5:0] tail_cell,
	output logic [4:0] rows_drawn,
	output logic [9:0] cells_drawn,
	output logic [7:0] refresh_count,
	output logic       last
);
	import drst_pkg::*;

	drst_cmd_t    cmd;
	drst_status_t status;

	drst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	drst_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.row           (row),
		.from_col      (from_col),
		.to_col        (to_col),
		.view_col      (view_col),
		.status        (status),
		.strobe        (strobe),
		.kind          (kind),
		.span_row      (span_row),
		.row_origin    (row_origin),
		.head_cell     (head_cell),
		.tail_cell     (tail_cell),
		.rows_drawn    (rows_drawn),
		.cells_drawn   (cells_drawn),
		.refresh_count (refresh_count),
		.last          (last)
	);

	// The end of every refresh is marked by its summary.
	a_sum_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && kind && last))
		else $error("refresh ended without a summary");

	// Span results only come out while a refresh is running.
	a_span_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !kind) |-> busy)
		else $error("span result outside a refresh");

	// An accepted refresh request starts the walk.
	a_refresh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_REFRESH) |=> busy)
		else $error("refresh request did not start a walk");

	// A summary result never shows before the walk is over.
	a_sum_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind) |-> !busy)
		else $error("summary shown during a walk");

endmodule

// ----- hdl/drst_ctrl.sv -----
// Controller of the dirty row span tracker: request decode and refresh sequencing.
module drst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2:0]          func,
	input  drst_pkg::drst_status_t status,
	output drst_pkg::drst_cmd_t cmd,
	output logic                busy
);
	import drst_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_SUM  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func)
						FUNC_MARK:    cmd.mark     = 1'b1;
						FUNC_ALL:     cmd.mark_all = 1'b1;
						FUNC_PAN:     cmd.pan      = 1'b1;
						FUNC_CLEAR:   cmd.clear    = 1'b1;
						FUNC_REFRESH: state_d      = ST_WALK;
						default:      ;
					endcase
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.walk_last)
					state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- hdl/drst_datapath.sv -----
// Datapath of the dirty row span tracker: span store, pan state and refresh arithmetic.
module drst_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  drst_pkg::drst_cmd_t    cmd,
	input  logic [4:0]             row,
	input  logic [6:0]             from_col,
	input  logic [6:0]             to_col,
	input  logic [6:0]             view_col,
	output drst_pkg::drst_status_t status,
	output logic                   strobe,
	output logic                   kind,
	output logic [4:0]             span_row,
	output logic [6:0]             row_origin,
	output logic [5:0]             head_cell,
	output logic [5:0]             tail_cell,
	output logic [4:0]             rows_drawn,
	output logic [9:0]             cells_drawn,
	output logic [7:0]             refresh_count,
	output logic                   last
);
	import drst_pkg::*;

	localparam int RW  = $clog2(TEXT_ROWS);
	localparam int RCW = $clog2(TEXT_ROWS + 1);
	localparam logic [COL_W-1:0]  CLEAN_COL = COL_W'(TEXT_COLS);
	localparam logic [COL_W-1:0]  MAX_COL   = COL_W'(TEXT_COLS - 1);
	localparam logic [RW-1:0]     LAST_ROW  = RW'(TEXT_ROWS - 1);
	localparam logic [WIDE_W-1:0] VIS_W     = WIDE_W'(VISIBLE_COLS);

	logic [COL_W-1:0] first_q [TEXT_ROWS];
	logic [COL_W-1:0] last_q  [TEXT_ROWS];
	logic [COL_W-1:0] pan_q;
	logic             unset_q;
	logic [7:0]       rcnt_q;
	logic [RW-1:0]    idx_q;
	logic [RCW-1:0]   rows_q;
	logic [9:0]       cells_q;

	logic [RW-1:0]    row_idx, rd_idx;
	logic             row_ok, pan_change;
	logic [COL_W-1:0] lo_sat, hi_sat, rd_first, rd_last;
	logic [WIDE_W-1:0] origin, rf, rf_end, lo, hi, lo_c, hi_c;
	logic             dirty, shown;
	logic [5:0]       fc, lc;
	logic [6:0]       row_cells;

	logic             strobe_q, kind_q, last_out_q;
	logic [4:0]       span_row_q, rows_out_q;
	logic [6:0]       origin_out_q;
	logic [5:0]       fc_q, lc_q;
	logic [9:0]       cells_out_q;
	logic [7:0]       count_out_q;

	assign row_idx    = RW'(row);
	assign row_ok     = ({1'b0, row} < 6'(TEXT_ROWS));
	assign lo_sat     = (from_col > MAX_COL) ? MAX_COL : from_col;
	assign hi_sat     = (to_col > MAX_COL) ? MAX_COL : to_col;
	assign pan_change = unset_q || (view_col != pan_q);

	// One read port serves both the mark widen and the refresh walk.
	assign rd_idx   = cmd.walk ? idx_q : row_idx;
	assign rd_first = first_q[rd_idx];
	assign rd_last  = last_q[rd_idx];

	assign origin = unset_q ? '0 : WIDE_W'(pan_q);
	assign rf     = (idx_q == '0 || idx_q == LAST_ROW) ? '0 : origin;
	assign rf_end = rf + VIS_W;
	assign lo     = WIDE_W'(rd_first);
	assign hi     = WIDE_W'(rd_last);
	assign dirty  = (rd_first <= rd_last);
	assign shown  = dirty && !(hi < rf || lo >= rf_end);
	assign lo_c   = (lo < rf) ? rf : lo;
	assign hi_c   = (hi >= rf_end) ? (rf_end - WIDE_W'(1)) : hi;
	assign fc     = 6'((lo_c - rf) >> 1);
	assign lc     = 6'((hi_c - rf) >> 1);
	assign row_cells = 7'({1'b0, lc} - {1'b0, fc} + 7'd1);

	assign status.walk_last = (idx_q == LAST_ROW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TEXT_ROWS; i++) begin
				first_q[i] <= CLEAN_COL;
				last_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < TEXT_ROWS; i++) begin
				if (cmd.mark_all || cmd.clear ||
				    (cmd.pan && pan_change && i != 0 && i != TEXT_ROWS - 1)) begin
					first_q[i] <= '0;
					last_q[i]  <= MAX_COL;
				end else if (cmd.mark && row_ok && row_idx == RW'(i)) begin
					if (lo_sat < rd_first)
						first_q[i] <= lo_sat;
					if (hi_sat > rd_last)
						last_q[i] <= hi_sat;
				end else if (cmd.walk && dirty && idx_q == RW'(i)) begin
					first_q[i] <= CLEAN_COL;
					last_q[i]  <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_q   <= '0;
			unset_q <= 1'b1;
			rcnt_q  <= '0;
			idx_q   <= '0;
			rows_q  <= '0;
			cells_q <= '0;
		end else begin
			if (cmd.clear) begin
				pan_q   <= '0;
				unset_q <= 1'b1;
			end else if (cmd.pan && pan_change) begin
				pan_q   <= view_col;
				unset_q <= 1'b0;
			end
			if (cmd.walk) begin
				idx_q <= status.walk_last ? '0 : idx_q + RW'(1);
				if (shown) begin
					rows_q  <= rows_q + RCW'(1);
					cells_q <= cells_q + 10'(row_cells);
				end
			end
			if (cmd.sum) begin
				rcnt_q  <= rcnt_q + 8'd1;
				rows_q  <= '0;
				cells_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= (cmd.walk && shown) || cmd.sum;
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			kind_q       <= 1'b1;
			span_row_q   <= '0;
			origin_out_q <= '0;
			fc_q         <= '0;
			lc_q         <= '0;
			rows_out_q   <= 5'(rows_q);
			cells_out_q  <= cells_q;
			count_out_q  <= rcnt_q + 8'd1;
			last_out_q   <= 1'b1;
		end else if (cmd.walk && shown) begin
			kind_q       <= 1'b0;
			span_row_q   <= 5'(idx_q);
			origin_out_q <= 7'(rf);
			fc_q         <= fc;
			lc_q         <= lc;
			rows_out_q   <= '0;
			cells_out_q  <= '0;
			count_out_q  <= '0;
			last_out_q   <= 1'b0;
		end
	end

	assign strobe        = strobe_q;
	assign kind          = kind_q;
	assign span_row      = span_row_q;
	assign row_origin    = origin_out_q;
	assign head_cell     = fc_q;
	assign tail_cell     = lc_q;
	assign rows_drawn    = rows_out_q;
	assign cells_drawn   = cells_out_q;
	assign refresh_count = count_out_q;
	assign last          = last_out_q;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the dirty row span tracker: directed and random requests.
`timescale 1ns / 100ps

module testbench;
	import drst_pkg::*;

	localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
	localparam logic       KIND_SPAN        = 1'b0;
	localparam logic       KIND_SUMMARY     = 1'b1;

	localparam int RANDOM_ITEMS   = 450;
	localparam int QUIET_ITEMS    = 120;
	localparam int STALL_LIMIT    = 1000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic       kind;
		logic [4:0] span_row;
		logic [6:0] row_origin;
		logic [5:0] head_cell;
		logic [5:0] tail_cell;
		logic [4:0] rows_drawn;
		logic [9:0] cells_drawn;
		logic [7:0] refresh_count;
		logic       last;
	} redraw_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] func;
	logic [4:0] row;
	logic [6:0] from_col;
	logic [6:0] to_col;
	logic [6:0] view_col;
	logic       strobe;
	logic       kind;
	logic [4:0] span_row;
	logic [6:0] row_origin;
	logic [5:0] head_cell;
	logic [5:0] tail_cell;
	logic [4:0] rows_drawn;
	logic [9:0] cells_drawn;
	logic [7:0] refresh_count;
	logic       last;

	// Shadow copy of the tracker state.
	logic [6:0] span_first [TEXT_ROWS];
	logic [6:0] span_last  [TEXT_ROWS];
	logic [6:0] pan_col;
	logic       pan_none;
	logic [7:0] refresh_total;

	redraw_t    pending_redraws[$];
	int         error_count;
	int         stall_cycles;
	bit         gaps_on;

	dirty_row_span_tracker u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.row           (row),
		.from_col      (from_col),
		.to_col        (to_col),
		.view_col      (view_col),
		.strobe        (strobe),
		.kind          (kind),
		.span_row      (span_row),
		.row_origin    (row_origin),
		.head_cell     (head_cell),
		.tail_cell     (tail_cell),
		.rows_drawn    (rows_drawn),
		.cells_drawn   (cells_drawn),
		.refresh_count (refresh_count),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [6:0] clamp_col(input logic [6:0] c);
		return (c > TEXT_COLS - 1) ? 7'(TEXT_COLS - 1) : c;
	endfunction

	function automatic void widen_row(input int r, input logic [6:0] lo, input logic [6:0] hi);
		if (lo < span_first[r])
			span_first[r] = lo;
		if (hi > span_last[r])
			span_last[r] = hi;
	endfunction

	function automatic void dirty_rows(input int first_row, input int last_row);
		for (int r = first_row; r <= last_row; r++)
			widen_row(r, 7'd0, 7'(TEXT_COLS - 1));
	endfunction

	function automatic void reset_tracker_model();
		for (int r = 0; r < TEXT_ROWS; r++) begin
			span_first[r] = 7'(TEXT_COLS);
			span_last[r]  = 7'd0;
		end
		pan_col       = 7'd0;
		pan_none      = 1'b1;
		refresh_total = 8'd0;
	endfunction

	// Updates the shadow state for one accepted request and queues its redraw results.
	task automatic predict_redraws(input logic [2:0] f, input logic [4:0] r, input logic [6:0] fc,
			input logic [6:0] tc, input logic [6:0] vc);
		int      lo, hi, origin, rf, rows, cells, c0, c1;
		redraw_t item;
		case (f)
			FUNC_MARK: begin
				if (r < TEXT_ROWS)
					widen_row(r, clamp_col(fc), clamp_col(tc));
			end
			FUNC_ALL: dirty_rows(0, TEXT_ROWS - 1);
			FUNC_PAN: begin
				if (pan_none || vc != pan_col) begin
					pan_col  = vc;
					pan_none = 1'b0;
					dirty_rows(1, TEXT_ROWS - 2);
				end
			end
			FUNC_CLEAR: begin
				pan_none = 1'b1;
				pan_col  = 7'd0;
				dirty_rows(0, TEXT_ROWS - 1);
			end
			FUNC_REFRESH: begin
				origin = pan_none ? 0 : int'(pan_col);
				rows   = 0;
				cells  = 0;
				for (int i = 0; i < TEXT_ROWS; i++) begin
					// The top and bottom rows never pan.
					rf = (i == 0 || i == TEXT_ROWS - 1) ? 0 : origin;
					lo = span_first[i];
					hi = span_last[i];
					if (lo > hi)
						continue;
					span_first[i] = 7'(TEXT_COLS);
					span_last[i]  = 7'd0;
					if (hi < rf || lo >= rf + VISIBLE_COLS)
						continue;
					if (lo < rf)
						lo = rf;
					if (hi >= rf + VISIBLE_COLS)
						hi = rf + VISIBLE_COLS - 1;
					c0 = (lo - rf) >> 1;
					c1 = (hi - rf) >> 1;
					rows++;
					cells += c1 - c0 + 1;
					item            = '0;
					item.kind       = KIND_SPAN;
					item.span_row   = 5'(i);
					item.row_origin = 7'(rf);
					item.head_cell  = 6'(c0);
					item.tail_cell  = 6'(c1);
					pending_redraws.push_back(item);
				end
				refresh_total++;
				item               = '0;
				item.kind          = KIND_SUMMARY;
				item.rows_drawn    = 5'(rows);
				item.cells_drawn   = 10'(cells);
				item.refresh_count = refresh_total;
				item.last          = 1'b1;
				pending_redraws.push_back(item);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Every strobed result is compared against the oldest queued redraw.
	always @(posedge clk) begin
		redraw_t want;
		if (arst_n && strobe === 1'b1) begin
			if (pending_redraws.size() == 0) begin
				report_mismatch("unexpected result", {31'd0, kind}, 32'd0);
			end else begin
				want = pending_redraws.pop_front();
				check_field("kind", 32'(kind), 32'(want.kind));
				check_field("span_row", 32'(span_row), 32'(want.span_row));
				check_field("row_origin", 32'(row_origin), 32'(want.row_origin));
				check_field("head_cell", 32'(head_cell), 32'(want.head_cell));
				check_field("tail_cell", 32'(tail_cell), 32'(want.tail_cell));
				check_field("rows_drawn", 32'(rows_drawn), 32'(want.rows_drawn));
				check_field("cells_drawn", 32'(cells_drawn), 32'(want.cells_drawn));
				check_field("refresh_count", 32'(refresh_count), 32'(want.refresh_count));
				check_field("last", 32'(last), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input logic [2:0] f, input logic [4:0] r, input logic [6:0] fc,
			input logic [6:0] tc, input logic [6:0] vc);
		if (gaps_on && $urandom_range(99) < 22) begin
			start    = 1'b0;
			func     = 3'($urandom);
			row      = 5'($urandom);
			from_col = 7'($urandom);
			to_col   = 7'($urandom);
			view_col = 7'($urandom);
			@(negedge clk);
		end
		start    = 1'b1;
		func     = f;
		row      = r;
		from_col = fc;
		to_col   = tc;
		view_col = vc;
		do
			@(posedge clk);
		while (busy);
		predict_redraws(f, r, fc, tc, vc);
		@(negedge clk);
	endtask

	task automatic wait_for_redraws();
		start = 1'b0;
		do
			@(negedge clk);
		while (pending_redraws.size() != 0);
	endtask

	task automatic test_clean_refresh();
		send_request(FUNC_REFRESH, 5'd0, 7'd0, 7'd0, 7'd0);
	endtask

	task automatic test_span_marks();
		send_request(FUNC_MARK, 5'd0, 7'd0, 7'd79, 7'd0);
		// A reversed span on a clean row leaves it clean.
		send_request(FUNC_MARK, 5'd23, 7'd79, 7'd0, 7'd127);
		send_request(FUNC_MARK, 5'd5, 7'd127, 7'd127, 7'd0);
		send_request(FUNC_MARK, 5'd31, 7'd0, 7'd79, 7'd0);
		send_request(FUNC_MARK, 5'd24, 7'd10, 7'd20, 7'd0);
		send_request(FUNC_MARK, 5'd7, 7'd50, 7'd10, 7'd0);
		send_request(FUNC_MARK, 5'd7, 7'd3, 7'd3, 7'd0);
		for (logic [3:0] f = 4'(FUNC_SPARE_FIRST); f <= 4'(FUNC_SPARE_LAST); f++)
			send_request(f[2:0], 5'd1, 7'd0, 7'd79, 7'd1);
		send_request(FUNC_REFRESH, 5'd31, 7'd127, 7'd127, 7'd127);
	endtask

	task automatic test_pan_window();
		// With no viewport, any pan column counts as a change, zero included.
		send_request(FUNC_PAN, 5'd0, 7'd0, 7'd0, 7'd0);
		send_request(FUNC_PAN, 5'd0, 7'd0, 7'd0, 7'd0);
		send_request(FUNC_MARK, 5'd0, 7'd70, 7'd79, 7'd0);
		send_request(FUNC_REFRESH, 5'd0, 7'd0, 7'd0, 7'd0);
		send_request(FUNC_PAN, 5'd0, 7'd0, 7'd0, 7'd79);
		send_request(FUNC_MARK, 5'd12, 7'd0, 7'd10, 7'd0);
		send_request(FUNC_REFRESH, 5'd0, 7'd0, 7'd0, 7'd0);
		send_request(FUNC_PAN, 5'd0, 7'd0, 7'd0, 7'd127);
		send_request(FUNC_REFRESH, 5'd0, 7'd0, 7'd0, 7'd0);
		send_request(FUNC_ALL, 5'd0, 7'd0, 7'd0, 7'd0);
		send_request(FUNC_REFRESH, 5'd0, 7'd0, 7'd0, 7'd0);
		send_request(FUNC_CLEAR, 5'd0, 7'd0, 7'd0, 7'd0);
		send_request(FUNC_REFRESH, 5'd0, 7'd0, 7'd0, 7'd0);
	endtask

	task automatic test_random_traffic();
		int         pick;
		logic [4:0] r;
		logic [6:0] fc, tc, vc;
		gaps_on = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == QUIET_ITEMS)
				gaps_on = 1'b1;
			if (n == RANDOM_ITEMS / 2)
				wait_for_redraws();
			r    = ($urandom_range(99) < 90) ? 5'($urandom_range(TEXT_ROWS - 1)) : 5'($urandom);
			if ($urandom_range(99) < 85) begin
				fc = 7'($urandom_range(TEXT_COLS - 1));
				tc = 7'($urandom_range(TEXT_COLS - 1));
				if ($urandom_range(99) < 80 && fc > tc) begin
					vc = fc;
					fc = tc;
					tc = vc;
				end
			end else begin
				fc = 7'($urandom);
				tc = 7'($urandom);
			end
			pick = $urandom_range(99);
			if (pick < 30)
				vc = pan_col;
			else if (pick < 90)
				vc = 7'($urandom_range(TEXT_COLS - 1));
			else
				vc = 7'($urandom);
			pick = $urandom_range(99);
			if (pick < 62)
				send_request(FUNC_MARK, r, fc, tc, vc);
			else if (pick < 72)
				send_request(FUNC_REFRESH, r, fc, tc, vc);
			else if (pick < 80)
				send_request(FUNC_PAN, r, fc, tc, vc);
			else if (pick < 85)
				send_request(FUNC_ALL, r, fc, tc, vc);
			else if (pick < 89)
				send_request(FUNC_CLEAR, r, fc, tc, vc);
			else
				send_request(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)), r, fc, tc, vc);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		func         = FUNC_MARK;
		row          = 5'd0;
		from_col     = 7'd0;
		to_col       = 7'd0;
		view_col     = 7'd0;
		error_count  = 0;
		stall_cycles = 0;
		gaps_on      = 1'b1;
		reset_tracker_model();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_clean_refresh();
		test_span_marks();
		test_pan_window();
		test_random_traffic();

		wait_for_redraws();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- dirty_row_span_tracker.f -----
hdl/drst_pkg.sv
hdl/drst_ctrl.sv
hdl/drst_datapath.sv
hdl/dirty_row_span_tracker.sv
tb/sv/testbench.sv
